// ===== hdl/proximity_reading_merger_macros.svh =====
// assertion macros shared by the proximity reading merger rtl
`ifndef PROXIMITY_READING_MERGER_MACROS_SVH
`define PROXIMITY_READING_MERGER_MACROS_SVH

// condition must hold at every clock edge out of reset
`define PRX_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define PRX_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PRX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/prx_pkg.sv =====
// types, constants and codes shared by the proximity reading merger
`timescale 1ns / 1ps

package prx_pkg;

    localparam int MAX_ITEMS = 16;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_AGG_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST = 1'd1;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] reading;
        logic signed [15:0] sink_id;
        logic [7:0]         subscription_id;
        logic               batch_end;
    } item_t;

    typedef struct packed {
        logic signed [15:0] out_sink;
        logic [7:0]         out_subscription;
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic signed [15:0] out_value;
        logic               overflow;
        logic               run_end;
    } result_t;

    // one stored reading
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] value;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    typedef enum logic [0:0] {
        ALU_NEAR,
        ALU_AVG
    } alu_op_t;

    typedef struct packed {
        alu_op_t            op;
        logic signed [15:0] a;
        logic signed [15:0] b;
    } alu_req_t;

    typedef struct packed {
        logic signed [15:0] result;
        logic               near;
    } alu_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_I_SCAN,
        ST_I_LOAD,
        ST_J_SCAN,
        ST_CMP_X,
        ST_CMP_Y,
        ST_AVG_V,
        ST_AVG_X,
        ST_AVG_Y,
        ST_WB,
        ST_EMIT_SCAN,
        ST_EMIT_OUT
    } state_t;

endpackage

// ===== hdl/prx_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module prx_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/prx_alu.sv =====
// shared add/subtract unit: per-axis distance check and truncated average
`timescale 1ns / 1ps

module prx_alu import prx_pkg::*; (
    input  alu_req_t    req,
    input  logic [15:0] max_dist,
    output alu_rsp_t    rsp
);

    logic               sub;
    logic signed [16:0] a_ext;
    logic signed [16:0] b_ext;
    logic signed [16:0] sum;
    logic [16:0]        mag;
    logic signed [16:0] rounded;
    logic signed [16:0] half;

    always_comb
    begin
        sub   = (req.op == ALU_NEAR);
        a_ext = {req.a[15], req.a};
        b_ext = {req.b[15], req.b};
        // one adder: a - b for the distance, a + b for the average
        sum   = a_ext + (sub ? ~b_ext : b_ext) + {16'd0, sub};
        mag   = sum[16] ? (~sum + 17'd1) : sum;
        // bias negatives by one so the shift truncates toward zero
        rounded = sum + $signed({16'd0, sum[16]});
        half    = rounded >>> 1;

        rsp.near   = (mag[15:0] <= max_dist);
        rsp.result = half[15:0];
    end

endmodule

// ===== hdl/proximity_reading_merger.sv =====
// top level: batch loader, merge sequencer and result emitter
`timescale 1ns / 1ps

`include "proximity_reading_merger_macros.svh"

// proximity reading merger
// readings are loaded one per start pulse into MAX_ITEMS slots; busy stays
// low between items of a batch. the item with batch_end set closes the
// batch (its sink and subscription tags apply to all results) and raises
// busy until the last result has gone out. items beyond the slot count are
// dropped and every result of that batch shows overflow. in pass mode the
// loaded slots are emitted in load order; in merge mode a sequencer sweeps
// slot pairs (i, j), j > i, through a single shared add/subtract unit: a
// live slot i is scanned, loaded, followed by the closing inner scan and
// written back; a live j is tested on x, then on y, and on a merge the
// value, x and y are averaged and slot j dies; dead slots are skipped.
// sweeps repeat until one full sweep makes no merge. emission then scans
// for each surviving reading and puts it out, skipping dead slots. each
// result is on the result port for exactly one cycle, marked by
// result_strobe; the receiver cannot stall, run_end marks the last beat of
// the batch, and busy drops in the cycle after it. configuration writes
// are taken only while busy is low (cfg_ready follows !busy); a write
// between items of a batch applies to that batch when it closes.
module proximity_reading_merger import prx_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,

    // item channel
    input  logic                  start,
    output logic                  busy,
    input  item_t                 item,

    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    // result channel, no backpressure
    output logic                  result_strobe,
    output result_t               result
);

    // configuration registers
    logic        agg_mode_reg;
    logic [15:0] max_dist_reg;

    // sequencer state
    state_t               state_reg,        state_next;
    logic [CNT_W-1:0]     i_reg,            i_next;
    logic [CNT_W-1:0]     j_reg,            j_next;
    logic [CNT_W-1:0]     loaded_count_reg, loaded_count_next;
    logic                 dropped_reg,      dropped_next;
    logic                 changed_reg,      changed_next;
    logic [MAX_ITEMS-1:0] slot_alive_reg,   slot_alive_next;

    // payload held across the sweep
    slot_t                work_reg,         work_next;
    logic signed [15:0]   sink_reg,         sink_next;
    logic [7:0]           sub_reg,          sub_next;

    // slot memory
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    slot_t                ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    slot_t                ram_rdata;

    // shared arithmetic
    alu_req_t             alu_req;
    alu_rsp_t             alu_rsp;

    logic                 last_alive;

    prx_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (MAX_ITEMS)
    ) u_slots (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    prx_alu u_alu (
        .req      (alu_req),
        .max_dist (max_dist_reg),
        .rsp      (alu_rsp)
    );

    // settings only change while no batch is being merged or emitted
    assign cfg_ready = !busy;
    assign busy      = (state_reg != ST_IDLE);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            agg_mode_reg <= 1'b0;
            max_dist_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_AGG_MODE: agg_mode_reg <= cfg_data[0];
                REG_MAX_DIST: max_dist_reg <= cfg_data[15:0];
                default:      agg_mode_reg <= agg_mode_reg;
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            i_reg            <= '0;
            j_reg            <= '0;
            loaded_count_reg <= '0;
            dropped_reg      <= 1'b0;
            changed_reg      <= 1'b0;
            slot_alive_reg   <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            i_reg            <= i_next;
            j_reg            <= j_next;
            loaded_count_reg <= loaded_count_next;
            dropped_reg      <= dropped_next;
            changed_reg      <= changed_next;
            slot_alive_reg   <= slot_alive_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        sink_reg <= sink_next;
        sub_reg  <= sub_next;
    end

    // no live slot above the one being emitted
    always_comb
    begin
        last_alive = 1'b1;
        for (int k = 0; k < MAX_ITEMS; k++)
        begin
            if (slot_alive_reg[k] && (CNT_W'(k) > i_reg))
            begin
                last_alive = 1'b0;
            end
        end
    end

    // read address: the i slot while scanning or loading i or emitting, else the j slot
    always_comb
    begin
        case (state_reg)
            ST_I_SCAN, ST_I_LOAD, ST_EMIT_SCAN, ST_EMIT_OUT: ram_raddr = i_reg[IDX_W-1:0];
            default:                                         ram_raddr = j_reg[IDX_W-1:0];
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        loaded_count_next = loaded_count_reg;
        dropped_next      = dropped_reg;
        changed_next      = changed_reg;
        slot_alive_next   = slot_alive_reg;
        work_next         = work_reg;
        sink_next         = sink_reg;
        sub_next          = sub_reg;
        ram_we            = 1'b0;
        ram_waddr         = i_reg[IDX_W-1:0];
        ram_wdata         = work_reg;
        alu_req.op        = ALU_NEAR;
        alu_req.a         = work_reg.x;
        alu_req.b         = ram_rdata.x;
        result_strobe     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (loaded_count_reg < CNT_W'(MAX_ITEMS))
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = loaded_count_reg[IDX_W-1:0];
                        ram_wdata = '{x: item.pos_x, y: item.pos_y, value: item.reading};
                        slot_alive_next[loaded_count_reg[IDX_W-1:0]] = 1'b1;
                        loaded_count_next = loaded_count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (item.batch_end)
                    begin
                        sink_next    = item.sink_id;
                        sub_next     = item.subscription_id;
                        i_next       = '0;
                        changed_next = 1'b0;
                        state_next   = agg_mode_reg ? ST_I_SCAN : ST_EMIT_SCAN;
                    end
                end
            end

            // outer loop: pick the next live slot i
            ST_I_SCAN:
            begin
                if (i_reg >= loaded_count_reg)
                begin
                    i_next = '0;
                    if (changed_reg)
                    begin
                        changed_next = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_EMIT_SCAN;
                    end
                end
                else if (slot_alive_reg[i_reg[IDX_W-1:0]])
                begin
                    j_next     = i_reg + CNT_W'(1);
                    state_next = ST_I_LOAD;
                end
                else
                begin
                    i_next = i_reg + CNT_W'(1);
                end
            end

            ST_I_LOAD:
            begin
                work_next  = ram_rdata;
                state_next = ST_J_SCAN;
            end

            // inner loop: pick the next live slot j
            ST_J_SCAN:
            begin
                if (j_reg >= loaded_count_reg)
                begin
                    state_next = ST_WB;
                end
                else if (slot_alive_reg[j_reg[IDX_W-1:0]])
                begin
                    state_next = ST_CMP_X;
                end
                else
                begin
                    j_next = j_reg + CNT_W'(1);
                end
            end

            ST_CMP_X:
            begin
                if (alu_rsp.near)
                begin
                    state_next = ST_CMP_Y;
                end
                else
                begin
                    j_next     = j_reg + CNT_W'(1);
                    state_next = ST_J_SCAN;
                end
            end

            ST_CMP_Y:
            begin
                alu_req.a = work_reg.y;
                alu_req.b = ram_rdata.y;
                if (alu_rsp.near)
                begin
                    state_next = ST_AVG_V;
                end
                else
                begin
                    j_next     = j_reg + CNT_W'(1);
                    state_next = ST_J_SCAN;
                end
            end

            ST_AVG_V:
            begin
                alu_req.op      = ALU_AVG;
                alu_req.a       = work_reg.value;
                alu_req.b       = ram_rdata.value;
                work_next.value = alu_rsp.result;
                state_next      = ST_AVG_X;
            end

            ST_AVG_X:
            begin
                alu_req.op  = ALU_AVG;
                work_next.x = alu_rsp.result;
                state_next  = ST_AVG_Y;
            end

            // last average, then slot j dies
            ST_AVG_Y:
            begin
                alu_req.op  = ALU_AVG;
                alu_req.a   = work_reg.y;
                alu_req.b   = ram_rdata.y;
                work_next.y = alu_rsp.result;
                slot_alive_next[j_reg[IDX_W-1:0]] = 1'b0;
                changed_next = 1'b1;
                j_next       = j_reg + CNT_W'(1);
                state_next   = ST_J_SCAN;
            end

            ST_WB:
            begin
                ram_we     = 1'b1;
                ram_waddr  = i_reg[IDX_W-1:0];
                ram_wdata  = work_reg;
                i_next     = i_reg + CNT_W'(1);
                state_next = ST_I_SCAN;
            end

            ST_EMIT_SCAN:
            begin
                if (i_reg >= loaded_count_reg)
                begin
                    slot_alive_next   = '0;
                    loaded_count_next = '0;
                    dropped_next      = 1'b0;
                    state_next        = ST_IDLE;
                end
                else if (slot_alive_reg[i_reg[IDX_W-1:0]])
                begin
                    state_next = ST_EMIT_OUT;
                end
                else
                begin
                    i_next = i_reg + CNT_W'(1);
                end
            end

            // one result beat; the batch closes on its last survivor
            ST_EMIT_OUT:
            begin
                result_strobe = 1'b1;
                if (last_alive)
                begin
                    slot_alive_next   = '0;
                    loaded_count_next = '0;
                    dropped_next      = 1'b0;
                    state_next        = ST_IDLE;
                end
                else
                begin
                    i_next     = i_reg + CNT_W'(1);
                    state_next = ST_EMIT_SCAN;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result.out_sink         = sink_reg;
        result.out_subscription = sub_reg;
        result.out_x            = ram_rdata.x;
        result.out_y            = ram_rdata.y;
        result.out_value        = ram_rdata.value;
        result.overflow         = dropped_reg;
        result.run_end          = last_alive;
    end

    // a beat only goes out from a live slot inside the loaded range
    `PRX_ASSERT_IMPL(a_emit_live, result_strobe, slot_alive_reg[i_reg[IDX_W-1:0]] && (i_reg < loaded_count_reg), "result from a dead or unloaded slot")

    // the last beat of a batch returns the block to idle with empty slots
    `PRX_ASSERT_NEXT(a_end_idle, result_strobe && result.run_end, !busy && (slot_alive_reg == '0) && (loaded_count_reg == '0), "batch not closed after last beat")

    // a merge always marks the sweep as changed and kills a slot
    `PRX_ASSERT_NEXT(a_merge_marks, state_reg == ST_AVG_Y, changed_reg && ($countones(slot_alive_reg) + 1 == $countones($past(slot_alive_reg))), "merge did not retire a slot")

    // fill count never passes the slot count
    `PRX_ASSERT_ALWAYS(a_count_range, loaded_count_reg <= CNT_W'(MAX_ITEMS), "loaded count out of range")

endmodule

// ===== tb/proximity_reading_merger_test.sv =====
// self-checking testbench for the proximity reading merger
`timescale 1ns / 1ps

module proximity_reading_merger_test;
    import prx_pkg::*;

    localparam int    RANDOM_READINGS = 350;
    localparam string PASS_LINE = "proximity_reading_merger regression: pass";
    localparam string FAIL_LINE = "proximity_reading_merger regression: fail";

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    item_t                 reading_beat;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  result_strobe;
    result_t               result_beat;

    proximity_reading_merger dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item          (reading_beat),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .result_strobe (result_strobe),
        .result        (result_beat)
    );

    // shadow of the block: configuration and the slots of the open batch
    bit        merge_mode;
    bit [15:0] reach_limit;
    int        slot_x [MAX_ITEMS];
    int        slot_y [MAX_ITEMS];
    int        slot_v [MAX_ITEMS];
    bit        slot_live [MAX_ITEMS];
    int        filled;
    bit        dropped;

    // expected results still to come out of the block, oldest first
    result_t   due_readings [$];
    int        failures;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // hard stop well past the slowest legal run
    initial
    begin
        #2_000_000;
        $display(FAIL_LINE);
        $finish;
    end

    function automatic bit close_enough(int a, int b);
        int d;
        d = a - b;
        if (d < 0)
            d = -d;
        return d <= int'(reach_limit);
    endfunction

    // pairwise sweeps until one full sweep merges nothing
    function automatic void coalesce_slots();
        bit changed;
        do
        begin
            changed = 1'b0;
            for (int i = 0; i < filled; i++)
            begin
                if (!slot_live[i])
                    continue;
                for (int j = i + 1; j < filled; j++)
                begin
                    if (!slot_live[j])
                        continue;
                    if (!close_enough(slot_x[i], slot_x[j]) ||
                        !close_enough(slot_y[i], slot_y[j]))
                        continue;
                    // int division truncates toward zero
                    slot_v[i] = (slot_v[i] + slot_v[j]) / 2;
                    slot_x[i] = (slot_x[i] + slot_x[j]) / 2;
                    slot_y[i] = (slot_y[i] + slot_y[j]) / 2;
                    slot_live[j] = 1'b0;
                    changed = 1'b1;
                end
            end
        end
        while (changed);
    endfunction

    // fold one accepted beat into the shadow; a closing beat yields the results
    function automatic void absorb_reading(item_t it);
        result_t r;
        int      last;
        if (filled < MAX_ITEMS)
        begin
            slot_x[filled]    = $signed(it.pos_x);
            slot_y[filled]    = $signed(it.pos_y);
            slot_v[filled]    = $signed(it.reading);
            slot_live[filled] = 1'b1;
            filled++;
        end
        else
            dropped = 1'b1;
        if (!it.batch_end)
            return;
        if (merge_mode)
            coalesce_slots();
        last = -1;
        for (int i = 0; i < filled; i++)
            if (slot_live[i])
                last = i;
        for (int i = 0; i < filled; i++)
        begin
            if (!slot_live[i])
                continue;
            r.out_sink         = it.sink_id;
            r.out_subscription = it.subscription_id;
            r.out_x            = slot_x[i][15:0];
            r.out_y            = slot_y[i][15:0];
            r.out_value        = slot_v[i][15:0];
            r.overflow         = dropped;
            r.run_end          = (i == last);
            due_readings.push_back(r);
        end
        for (int i = 0; i < MAX_ITEMS; i++)
            slot_live[i] = 1'b0;
        filled  = 0;
        dropped = 1'b0;
    endfunction

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endtask

    // every result beat is taken at the edge that ends its strobe cycle
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_strobe)
        begin
            if (due_readings.size() == 0)
            begin
                $error("result beat with nothing expected");
                failures++;
            end
            else
            begin
                want = due_readings.pop_front();
                check_field("out_sink", want.out_sink, result_beat.out_sink);
                check_field("out_subscription", {8'd0, want.out_subscription},
                            {8'd0, result_beat.out_subscription});
                check_field("out_x", want.out_x, result_beat.out_x);
                check_field("out_y", want.out_y, result_beat.out_y);
                check_field("out_value", want.out_value, result_beat.out_value);
                check_field("overflow", {15'd0, want.overflow},
                            {15'd0, result_beat.overflow});
                check_field("run_end", {15'd0, want.run_end},
                            {15'd0, result_beat.run_end});
            end
        end
    end

    // one reading beat after a hold-off of idle cycles; busy is stable at
    // the falling edge, so a low busy there means the next rising edge takes it
    task automatic send_reading(item_t it, int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start        <= 1'b1;
        reading_beat <= it;
        while (busy)
            @(negedge clk);
        @(posedge clk);
        absorb_reading(it);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        start     <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        if (idx == REG_AGG_MODE)
            merge_mode = data[0];
        else
            reach_limit = data;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // block quiet: nothing owed, busy low, and then a settling margin
    task automatic wait_idle();
        @(negedge clk);
        start <= 1'b0;
        while (due_readings.size() != 0 || busy)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic item_t make_reading(int x, int y, int v, int sink, int sub, bit fin);
        item_t it;
        it.pos_x           = x[15:0];
        it.pos_y           = y[15:0];
        it.reading         = v[15:0];
        it.sink_id         = sink[15:0];
        it.subscription_id = sub[7:0];
        it.batch_end       = fin;
        return it;
    endfunction

    // pass mode out of reset: extreme coordinates, values and tags
    task automatic test_pass_extremes();
        send_reading(make_reading(-32768, 32767, -32768, 5, 9, 1'b0), 0);
        send_reading(make_reading(32767, -32768, 32767, -7, 3, 1'b0), 2);
        send_reading(make_reading(0, -1, 1, -32768, 255, 1'b1), 0);
        send_reading(make_reading(-1, -1, -1, 32767, 0, 1'b1), 5);
        wait_idle();
    endtask

    // merge mode at both ends of the distance range, odd and negative sums
    task automatic test_merge_limits();
        write_register(REG_AGG_MODE, 16'hFFFF);     // upper bits ignored
        write_register(REG_MAX_DIST, 16'd0);
        send_reading(make_reading(5, 5, 10, 0, 0, 1'b0), 0);
        send_reading(make_reading(5, 5, -3, 0, 0, 1'b0), 0);
        send_reading(make_reading(7, 5, 1, 0, 0, 1'b0), 0);
        send_reading(make_reading(5, 5, 4, 100, 17, 1'b1), 0);
        wait_idle();
        write_register(REG_MAX_DIST, 16'hFFFF);
        send_reading(make_reading(-32768, -32768, -32768, 0, 0, 1'b0), 1);
        send_reading(make_reading(32767, 32767, 32767, 0, 0, 1'b0), 0);
        send_reading(make_reading(-1, 1, -3, -200, 128, 1'b1), 3);
        wait_idle();
        write_register(REG_MAX_DIST, 16'd2);
        send_reading(make_reading(-3, 0, -5, 0, 0, 1'b0), 0);
        send_reading(make_reading(-6, 2, -2, 0, 0, 1'b0), 0);
        send_reading(make_reading(-4, 1, 7, 1, 1, 1'b1), 0);
        wait_idle();
    endtask

    // one reading past the slot count, the closing beat itself dropped
    task automatic test_overflow();
        write_register(REG_AGG_MODE, 16'hAAAA);     // bit zero clear: pass mode
        for (int k = 0; k < MAX_ITEMS + 1; k++)
            send_reading(make_reading(k * 100, -k, k - 8, 0, 0, k == MAX_ITEMS), 0);
        wait_idle();
    endtask

    // clustered batches of random size and content, settings changed now and then
    task automatic test_random_batches();
        int    sent;
        int    batch_no;
        int    size;
        int    cx;
        int    cy;
        int    spread;
        int    off_x;
        int    off_y;
        int    gap;
        bit    burst;
        item_t it;
        sent     = 0;
        batch_no = 0;
        while (sent < RANDOM_READINGS)
        begin
            if (batch_no % 4 == 0)
            begin
                wait_idle();
                write_register(REG_AGG_MODE, 16'($urandom));
                case ($urandom_range(0, 3))
                    0: write_register(REG_MAX_DIST, 16'd0);
                    1: write_register(REG_MAX_DIST, 16'hFFFF);
                    2: write_register(REG_MAX_DIST, 16'($urandom_range(0, 64)));
                    default: write_register(REG_MAX_DIST, 16'($urandom));
                endcase
            end
            case ($urandom_range(0, 7))
                0: size = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 3);
                1: size = MAX_ITEMS;
                default: size = $urandom_range(1, 12);
            endcase
            cx     = int'($urandom_range(0, 60000)) - 30000;
            cy     = int'($urandom_range(0, 60000)) - 30000;
            spread = $urandom_range(0, 200);
            burst  = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < size; k++)
            begin
                it = make_reading(0, 0, 0, 0, 0, k == size - 1);
                it.reading         = 16'($urandom);
                it.sink_id         = 16'($urandom);
                it.subscription_id = 8'($urandom);
                if ($urandom_range(0, 4) == 0)
                begin
                    it.pos_x = 16'($urandom);
                    it.pos_y = 16'($urandom);
                end
                else
                begin
                    off_x = int'($urandom_range(0, 2 * spread)) - spread;
                    off_y = int'($urandom_range(0, 2 * spread)) - spread;
                    it.pos_x = 16'(cx + off_x);
                    it.pos_y = 16'(cy + off_y);
                end
                gap = burst ? 0 : $urandom_range(0, 18);
                send_reading(it, gap);
                sent++;
            end
            batch_no++;
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        reading_beat = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        merge_mode   = 1'b0;
        reach_limit  = '0;
        filled       = 0;
        dropped      = 1'b0;
        failures     = 0;
        foreach (slot_live[i])
            slot_live[i] = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_pass_extremes();
        test_merge_limits();
        test_overflow();
        test_random_batches();

        wait_idle();
        repeat (40) @(negedge clk);
        if (due_readings.size() != 0)
        begin
            $error("%0d expected results never arrived", due_readings.size());
            failures++;
        end
        if (failures == 0)
            $display(PASS_LINE);
        else
            $display(FAIL_LINE);
        $finish;
    end

endmodule
